// File: rtl/rps_pkg.sv
// Shared types, widths and codes of the reachability pattern scorer.
// Depends on nothing; the other files but rps_ram refer to it by scoped names.
package rps_pkg;

	// Sizes of the stores; all powers of two so a table address is a bit concatenation
	localparam int MAX_X      = 16;
	localparam int MAX_Y      = 16;
	localparam int MAX_Z      = 8;
	localparam int MAX_ORI    = 32;
	localparam int MAX_POINTS = 64;
	localparam int MAX_PATHS  = 8;

	localparam int X_W    = $clog2(MAX_X);
	localparam int Y_W    = $clog2(MAX_Y);
	localparam int Z_W    = $clog2(MAX_Z);
	localparam int ORI_W  = $clog2(MAX_ORI);
	localparam int TBL_AW = ORI_W + X_W + Y_W + Z_W;
	localparam int TBL_DEPTH = MAX_ORI * MAX_X * MAX_Y * MAX_Z;
	localparam int PT_AW  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int PATH_W = $clog2(MAX_PATHS);

	// Field widths of the transactions
	localparam int OP_W     = 2;
	localparam int ORIF_W   = 5;
	localparam int CXY_W    = 6;
	localparam int CZ_W     = 4;
	localparam int SCORE_W  = 16;
	localparam int PATHF_W  = 3;
	localparam int OFS_W    = 7;
	localparam int TOTAL_W  = 19;
	localparam int MASK_W   = 8;
	// Shifted coordinate: unsigned cell plus signed offset
	localparam int COORD_W  = CXY_W + 2;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int CFGX_W   = 5;
	localparam int CFGY_W   = 5;
	localparam int CFGZ_W   = 4;
	localparam int CFGO_W   = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORI    = 2'd3;

	// Effective (clamped) counts
	localparam int NX_W = $clog2(MAX_X + 1);
	localparam int NY_W = $clog2(MAX_Y + 1);
	localparam int NZ_W = $clog2(MAX_Z + 1);
	localparam int NO_W = $clog2(MAX_ORI + 1);

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_APPEND = 2'd2,
		OP_SCORE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [ORIF_W-1:0]  ori;
		logic [CXY_W-1:0]   x;
		logic [CXY_W-1:0]   y;
		logic [CZ_W-1:0]    z;
		logic [PATH_W-1:0]  path;
	} pt_t;

	typedef struct packed {
		logic [NX_W-1:0] nx;
		logic [NY_W-1:0] ny;
		logic [NZ_W-1:0] nz;
		logic [NO_W-1:0] no;
	} grid_t;

	typedef struct packed {
		logic              clear;
		logic              upd;
		logic              upd_inrange;
		logic [PATH_W-1:0] upd_path;
		logic              sum;
		logic [PATH_W-1:0] sum_idx;
	} acc_ctrl_t;

endpackage

// File: rtl/rps_chan_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on rps_pkg for field widths.
interface rps_in_if;
	logic                          valid;
	logic                          ready;
	logic [rps_pkg::OP_W-1:0]      opcode;
	logic [rps_pkg::ORIF_W-1:0]    ori_index;
	logic [rps_pkg::CXY_W-1:0]     cell_x;
	logic [rps_pkg::CXY_W-1:0]     cell_y;
	logic [rps_pkg::CZ_W-1:0]      cell_z;
	logic [rps_pkg::SCORE_W-1:0]   score_value;
	logic [rps_pkg::PATHF_W-1:0]   path_index;
	logic signed [rps_pkg::OFS_W-1:0] offset_x;
	logic signed [rps_pkg::OFS_W-1:0] offset_y;

	modport source (output valid, opcode, ori_index, cell_x, cell_y, cell_z, score_value,
		path_index, offset_x, offset_y, input ready);
	modport sink (input valid, opcode, ori_index, cell_x, cell_y, cell_z, score_value,
		path_index, offset_x, offset_y, output ready);
endinterface

interface rps_out_if;
	logic                          valid;
	logic                          ready;
	logic [rps_pkg::TOTAL_W-1:0]   total_score;
	logic [rps_pkg::MASK_W-1:0]    path_mask;
	logic                          is_match;

	modport source (output valid, total_score, path_mask, is_match, input ready);
	modport sink (input valid, total_score, path_mask, is_match, output ready);
endinterface

// File: rtl/rps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the score table and the pattern store.
module rps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/rps_acc.sv
// Per-path minimum tracker and final path sum for a score transaction.
// Depends on rps_pkg; driven by the sequencer in rps_seq.
module rps_acc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rps_pkg::acc_ctrl_t            ctrl,
	input  logic [rps_pkg::SCORE_W-1:0]   tbl_rdata,
	output logic [rps_pkg::TOTAL_W-1:0]   total,
	output logic [rps_pkg::MASK_W-1:0]    mask
);

	logic [rps_pkg::SCORE_W-1:0]   minima_q [rps_pkg::MAX_PATHS];
	logic [rps_pkg::MAX_PATHS-1:0] seen_q;
	logic [rps_pkg::TOTAL_W-1:0]   total_q;
	logic [rps_pkg::MAX_PATHS-1:0] mask_q;
	logic [rps_pkg::SCORE_W-1:0]   cell_score;
	logic                          take_lower;
	logic [rps_pkg::SCORE_W-1:0]   sum_min;
	logic                          sum_take;

	// A point outside the grid in use scores zero
	assign cell_score = ctrl.upd_inrange ? tbl_rdata : '0;
	assign take_lower = !seen_q[ctrl.upd_path] || (cell_score < minima_q[ctrl.upd_path]);

	assign sum_min  = minima_q[ctrl.sum_idx];
	assign sum_take = seen_q[ctrl.sum_idx] && (sum_min != '0);

	// Track minima; the minima themselves are payload and need no reset
	always_ff @(posedge clk) begin
		if (ctrl.upd && take_lower) begin
			minima_q[ctrl.upd_path] <= cell_score;
		end
	end

	// Seen flags, running total and mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			total_q <= '0;
			mask_q  <= '0;
		end else if (ctrl.clear) begin
			seen_q  <= '0;
			total_q <= '0;
			mask_q  <= '0;
		end else begin
			if (ctrl.upd) begin
				seen_q[ctrl.upd_path] <= 1'b1;
			end
			// Eight 16-bit minima fit in 19 bits, so the sum never saturates
			if (ctrl.sum && sum_take) begin
				total_q <= total_q + rps_pkg::TOTAL_W'(sum_min);
				mask_q[ctrl.sum_idx] <= 1'b1;
			end
		end
	end

	assign total = total_q;
	assign mask  = rps_pkg::MASK_W'(mask_q);

endmodule

// File: rtl/rps_seq.sv
// Sequencer: decodes transactions, walks the pattern through a three-stage
// read pipeline, steps the path sum and holds the result register. Depends on rps_pkg.
module rps_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rps_pkg::grid_t               grid,
	rps_in_if.sink                       in_ch,
	rps_out_if.source                    out_ch,
	output logic                         pat_we,
	output logic [rps_pkg::PT_AW-1:0]    pat_waddr,
	output rps_pkg::pt_t                 pat_wdata,
	output logic [rps_pkg::PT_AW-1:0]    pat_raddr,
	input  rps_pkg::pt_t                 pat_rdata,
	output logic                         tbl_we,
	output logic [rps_pkg::TBL_AW-1:0]   tbl_waddr,
	output logic [rps_pkg::SCORE_W-1:0]  tbl_wdata,
	output logic [rps_pkg::TBL_AW-1:0]   tbl_raddr,
	output rps_pkg::acc_ctrl_t           acc,
	input  logic [rps_pkg::TOTAL_W-1:0]  acc_total,
	input  logic [rps_pkg::MASK_W-1:0]   acc_mask
);

	rps_pkg::state_t state_q, state_d;

	logic [rps_pkg::CNT_W-1:0]        count_q;
	logic [rps_pkg::CNT_W-1:0]        i_q;
	logic [rps_pkg::PATH_W-1:0]       sum_idx_q;
	logic signed [rps_pkg::OFS_W-1:0] dx_q, dy_q;
	logic                             valid_s1, valid_s2;
	logic                             inrange_s2;
	logic [rps_pkg::PATH_W-1:0]       path_s2;
	logic                             out_valid_q;
	logic [rps_pkg::TOTAL_W-1:0]      out_total_q;
	logic [rps_pkg::MASK_W-1:0]       out_mask_q;
	logic                             out_match_q;

	logic in_ready, accept, issue, load_out, sum_en;
	logic signed [rps_pkg::COORD_W-1:0] sx, sy;
	logic x_ok, y_ok, z_ok, o_ok;

	assign accept = in_ch.valid && in_ready;
	assign in_ch.ready = in_ready;

	// Next state and per-state strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		sum_en   = 1'b0;
		case (state_q)
			rps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_ch.valid && in_ch.opcode == rps_pkg::OP_SCORE) begin
					state_d = rps_pkg::ST_WALK;
				end
			end
			rps_pkg::ST_WALK: begin
				if (i_q < count_q) begin
					issue = 1'b1;
				end else begin
					state_d = rps_pkg::ST_DRAIN;
				end
			end
			rps_pkg::ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = rps_pkg::ST_SUM;
				end
			end
			rps_pkg::ST_SUM: begin
				sum_en = 1'b1;
				if (sum_idx_q == rps_pkg::PATH_W'(rps_pkg::MAX_PATHS - 1)) begin
					state_d = rps_pkg::ST_OUT;
				end
			end
			rps_pkg::ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = rps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rps_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table write straight from an accepted write transaction; drop out-of-range cells
	assign tbl_we = accept && in_ch.opcode == rps_pkg::OP_WRITE
		&& 32'(in_ch.ori_index) < rps_pkg::MAX_ORI && 32'(in_ch.cell_x) < rps_pkg::MAX_X
		&& 32'(in_ch.cell_y) < rps_pkg::MAX_Y && 32'(in_ch.cell_z) < rps_pkg::MAX_Z;
	assign tbl_waddr = {in_ch.ori_index[rps_pkg::ORI_W-1:0], in_ch.cell_x[rps_pkg::X_W-1:0],
		in_ch.cell_y[rps_pkg::Y_W-1:0], in_ch.cell_z[rps_pkg::Z_W-1:0]};
	assign tbl_wdata = in_ch.score_value;

	// Append a point unless the pattern is full or the path is out of range
	assign pat_we = accept && in_ch.opcode == rps_pkg::OP_APPEND
		&& count_q < rps_pkg::CNT_W'(rps_pkg::MAX_POINTS)
		&& 32'(in_ch.path_index) < rps_pkg::MAX_PATHS;
	assign pat_waddr = count_q[rps_pkg::PT_AW-1:0];
	assign pat_wdata = '{ori: in_ch.ori_index, x: in_ch.cell_x, y: in_ch.cell_y,
		z: in_ch.cell_z, path: in_ch.path_index[rps_pkg::PATH_W-1:0]};

	// Stage 0: read the next stored point
	assign pat_raddr = i_q[rps_pkg::PT_AW-1:0];

	// Stage 1: shift the point, check it against the grid in use, read the table
	assign sx = rps_pkg::COORD_W'(signed'({2'b00, pat_rdata.x}))
		+ rps_pkg::COORD_W'(dx_q);
	assign sy = rps_pkg::COORD_W'(signed'({2'b00, pat_rdata.y}))
		+ rps_pkg::COORD_W'(dy_q);
	assign x_ok = !sx[rps_pkg::COORD_W-1]
		&& (sx[rps_pkg::COORD_W-2:0] < (rps_pkg::COORD_W-1)'(grid.nx));
	assign y_ok = !sy[rps_pkg::COORD_W-1]
		&& (sy[rps_pkg::COORD_W-2:0] < (rps_pkg::COORD_W-1)'(grid.ny));
	assign z_ok = rps_pkg::NZ_W'(pat_rdata.z) < grid.nz;
	assign o_ok = rps_pkg::NO_W'(pat_rdata.ori) < grid.no;
	assign tbl_raddr = {pat_rdata.ori[rps_pkg::ORI_W-1:0], sx[rps_pkg::X_W-1:0],
		sy[rps_pkg::Y_W-1:0], pat_rdata.z[rps_pkg::Z_W-1:0]};

	// Stage 2: table data meets the minimum tracker
	always_comb begin
		acc             = '0;
		acc.clear       = accept && in_ch.opcode == rps_pkg::OP_SCORE;
		acc.upd         = valid_s2;
		acc.upd_inrange = inrange_s2;
		acc.upd_path    = path_s2;
		acc.sum         = sum_en;
		acc.sum_idx     = sum_idx_q;
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		inrange_s2 <= x_ok && y_ok && z_ok && o_ok;
		path_s2    <= pat_rdata.path;
		if (accept && in_ch.opcode == rps_pkg::OP_SCORE) begin
			dx_q <= in_ch.offset_x;
			dy_q <= in_ch.offset_y;
		end
		if (load_out) begin
			out_total_q <= acc_total;
			out_mask_q  <= acc_mask;
			out_match_q <= acc_total != '0;
		end
	end

	// Control: point count, walk index, sum index, stage valids, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			i_q         <= '0;
			sum_idx_q   <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (accept && in_ch.opcode == rps_pkg::OP_CLEAR) begin
				count_q <= '0;
			end
			if (pat_we) begin
				count_q <= count_q + 1'b1;
			end
			if (accept && in_ch.opcode == rps_pkg::OP_SCORE) begin
				i_q       <= '0;
				sum_idx_q <= '0;
			end
			if (issue) begin
				i_q <= i_q + 1'b1;
			end
			if (sum_en) begin
				sum_idx_q <= sum_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.total_score = out_total_q;
	assign out_ch.path_mask   = out_mask_q;
	assign out_ch.is_match    = out_match_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rps_pkg::CNT_W'(rps_pkg::MAX_POINTS))
		else $error("point count above pattern capacity");

	// A clear between scores may drop the count below the old walk index
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rps_pkg::ST_WALK) |-> (i_q <= count_q))
		else $error("walk index passed the point count");

	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("stage 2 valid without stage 1 the cycle before");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!valid_s1 && !valid_s2))
		else $error("new transaction accepted with points in flight");

	a_match_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_match_q == (out_total_q != '0)))
		else $error("is_match disagrees with total_score");

endmodule

// File: rtl/reachability_pattern_scorer.sv
// Reachability pattern scorer: write, clear and append and score transactions.
// Write, clear and append leave ready high, so they can follow back to back.
// A score runs the pattern walk (one table read per point through a three-stage
// pipeline), then a drain and an eight-step path sum.
// Input ready is low during a score; a finished result waits in an output register.
// Reset clears the point count and restores the full grid configuration; the stores are not cleared.
module reachability_pattern_scorer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rps_pkg::CFG_DATA_W-1:0]  cfg_data,
	rps_in_if.sink                          in_ch,
	rps_out_if.source                       out_ch
);

	logic [rps_pkg::CFGX_W-1:0] grid_x_q;
	logic [rps_pkg::CFGY_W-1:0] grid_y_q;
	logic [rps_pkg::CFGZ_W-1:0] grid_z_q;
	logic [rps_pkg::CFGO_W-1:0] ori_q;
	rps_pkg::grid_t             grid;

	logic                          pat_we;
	logic [rps_pkg::PT_AW-1:0]     pat_waddr, pat_raddr;
	rps_pkg::pt_t                  pat_wdata, pat_rdata;
	logic                          tbl_we;
	logic [rps_pkg::TBL_AW-1:0]    tbl_waddr, tbl_raddr;
	logic [rps_pkg::SCORE_W-1:0]   tbl_wdata, tbl_rdata;
	rps_pkg::acc_ctrl_t            acc;
	logic [rps_pkg::TOTAL_W-1:0]   acc_total;
	logic [rps_pkg::MASK_W-1:0]    acc_mask;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_x_q <= rps_pkg::CFGX_W'(16);
			grid_y_q <= rps_pkg::CFGY_W'(16);
			grid_z_q <= rps_pkg::CFGZ_W'(8);
			ori_q    <= rps_pkg::CFGO_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				rps_pkg::CFG_GRID_X: grid_x_q <= cfg_data[rps_pkg::CFGX_W-1:0];
				rps_pkg::CFG_GRID_Y: grid_y_q <= cfg_data[rps_pkg::CFGY_W-1:0];
				rps_pkg::CFG_GRID_Z: grid_z_q <= cfg_data[rps_pkg::CFGZ_W-1:0];
				rps_pkg::CFG_ORI:    ori_q    <= cfg_data[rps_pkg::CFGO_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp each count to its store size
	always_comb begin
		grid.nx = (32'(grid_x_q) > rps_pkg::MAX_X) ? rps_pkg::NX_W'(rps_pkg::MAX_X)
			: rps_pkg::NX_W'(grid_x_q);
		grid.ny = (32'(grid_y_q) > rps_pkg::MAX_Y) ? rps_pkg::NY_W'(rps_pkg::MAX_Y)
			: rps_pkg::NY_W'(grid_y_q);
		grid.nz = (32'(grid_z_q) > rps_pkg::MAX_Z) ? rps_pkg::NZ_W'(rps_pkg::MAX_Z)
			: rps_pkg::NZ_W'(grid_z_q);
		grid.no = (32'(ori_q) > rps_pkg::MAX_ORI) ? rps_pkg::NO_W'(rps_pkg::MAX_ORI)
			: rps_pkg::NO_W'(ori_q);
	end

	rps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid      (grid),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.pat_we    (pat_we),
		.pat_waddr (pat_waddr),
		.pat_wdata (pat_wdata),
		.pat_raddr (pat_raddr),
		.pat_rdata (pat_rdata),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata),
		.tbl_raddr (tbl_raddr),
		.acc       (acc),
		.acc_total (acc_total),
		.acc_mask  (acc_mask)
	);

	rps_ram #(
		.WIDTH ($bits(rps_pkg::pt_t)),
		.DEPTH (rps_pkg::MAX_POINTS)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	rps_ram #(
		.WIDTH (rps_pkg::SCORE_W),
		.DEPTH (rps_pkg::TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	rps_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (acc),
		.tbl_rdata (tbl_rdata),
		.total     (acc_total),
		.mask      (acc_mask)
	);

endmodule

// File: sim/testbench.sv
// Self-checking testbench for reachability_pattern_scorer: drives table writes, pattern
// edits and scores, predicts each score result and compares it with the block's output.
// Depends on rps_pkg and the rps_in_if / rps_out_if channel interfaces.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int ITEM_TARGET  = 1300;
	localparam int DRAIN_CYCLES = rps_pkg::MAX_POINTS + 40;
	localparam int OFS_MAX      = 63;

	typedef struct {
		rps_pkg::op_t                     opcode;
		logic [rps_pkg::ORIF_W-1:0]       ori;
		logic [rps_pkg::CXY_W-1:0]        x;
		logic [rps_pkg::CXY_W-1:0]        y;
		logic [rps_pkg::CZ_W-1:0]         z;
		logic [rps_pkg::SCORE_W-1:0]      value;
		logic [rps_pkg::PATHF_W-1:0]      path;
		logic signed [rps_pkg::OFS_W-1:0] dx;
		logic signed [rps_pkg::OFS_W-1:0] dy;
	} txn_t;

	typedef struct {
		logic [rps_pkg::TOTAL_W-1:0] total;
		logic [rps_pkg::MASK_W-1:0]  mask;
		logic                        match;
	} score_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rps_pkg::CFG_DATA_W-1:0] cfg_data;

	rps_in_if  in_ch ();
	rps_out_if out_ch ();

	reachability_pattern_scorer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Predictor state: score cells, which cells hold data, the pattern and the grid
	logic [rps_pkg::SCORE_W-1:0] cell_scores [rps_pkg::TBL_DEPTH];
	bit                          cell_written [rps_pkg::TBL_DEPTH];
	rps_pkg::pt_t                stored_pts [$];
	int                          grid_x_n = 16;
	int                          grid_y_n = 16;
	int                          grid_z_n = 8;
	int                          ori_n = 32;
	score_t                      expected_scores [$];

	int cycle_count = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int burst_left = 0;
	int hold_request = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("ERROR cycle %0d: %s", cycle_count, what);
	endtask

	function automatic int in_use(input int n, input int lim);
		return (n > lim) ? lim : n;
	endfunction

	function automatic int cell_index(input int o, input int x, input int y, input int z);
		return ((o * rps_pkg::MAX_X + x) * rps_pkg::MAX_Y + y) * rps_pkg::MAX_Z + z;
	endfunction

	// Locate a shifted pattern point; returns 0 when it lies outside the grid in use
	function automatic bit grid_cell(input rps_pkg::pt_t p, input int dx, input int dy,
			output int addr);
		int sx;
		int sy;
		sx = int'(p.x) + dx;
		sy = int'(p.y) + dy;
		addr = 0;
		if (sx < 0 || sy < 0)
			return 0;
		if (int'(p.ori) >= in_use(ori_n, rps_pkg::MAX_ORI) ||
				sx >= in_use(grid_x_n, rps_pkg::MAX_X) ||
				sy >= in_use(grid_y_n, rps_pkg::MAX_Y) ||
				int'(p.z) >= in_use(grid_z_n, rps_pkg::MAX_Z))
			return 0;
		addr = cell_index(p.ori, sx, sy, p.z);
		return 1;
	endfunction

	// Per-path minimum over shifted points, then sum and mask the positive minima
	function automatic score_t score_pattern(input int dx, input int dy);
		int     low [rps_pkg::MAX_PATHS];
		bit     seen [rps_pkg::MAX_PATHS];
		int     addr;
		int     s;
		int     sum;
		int     p;
		score_t r;
		for (p = 0; p < rps_pkg::MAX_PATHS; p++) begin
			low[p] = 0;
			seen[p] = 0;
		end
		foreach (stored_pts[i]) begin
			p = stored_pts[i].path;
			s = grid_cell(stored_pts[i], dx, dy, addr) ? int'(cell_scores[addr]) : 0;
			if (!seen[p] || s < low[p])
				low[p] = s;
			seen[p] = 1;
		end
		sum = 0;
		r.mask = '0;
		for (p = 0; p < rps_pkg::MAX_PATHS; p++) begin
			if (seen[p] && low[p] > 0) begin
				sum += low[p];
				if (sum > 524287)
					sum = 524287;
				if (p < rps_pkg::MASK_W)
					r.mask[p] = 1'b1;
			end
		end
		r.total = rps_pkg::TOTAL_W'(sum);
		r.match = (sum > 0);
		return r;
	endfunction

	// True when every in-grid read of a score at this offset hits a written cell
	function automatic bit reads_defined(input int dx, input int dy);
		int addr;
		foreach (stored_pts[i]) begin
			if (grid_cell(stored_pts[i], dx, dy, addr) && !cell_written[addr])
				return 0;
		end
		return 1;
	endfunction

	// Advance the predictor by one accepted transaction
	function automatic void apply_txn(input txn_t t);
		int addr;
		rps_pkg::pt_t p;
		case (t.opcode)
			rps_pkg::OP_WRITE: begin
				if (t.ori < rps_pkg::MAX_ORI && t.x < rps_pkg::MAX_X && t.y < rps_pkg::MAX_Y
						&& t.z < rps_pkg::MAX_Z) begin
					addr = cell_index(t.ori, t.x, t.y, t.z);
					cell_scores[addr] = t.value;
					cell_written[addr] = 1;
				end
			end
			rps_pkg::OP_CLEAR: begin
				stored_pts.delete();
			end
			rps_pkg::OP_APPEND: begin
				if (stored_pts.size() < rps_pkg::MAX_POINTS && t.path < rps_pkg::MAX_PATHS) begin
					p.ori = t.ori;
					p.x = t.x;
					p.y = t.y;
					p.z = t.z;
					p.path = t.path;
					stored_pts.insert(stored_pts.size(), p);
				end
			end
			rps_pkg::OP_SCORE: begin
				expected_scores.insert(expected_scores.size(), score_pattern(t.dx, t.dy));
			end
			default: ;
		endcase
	endfunction

	function automatic txn_t rand_txn(input rps_pkg::op_t op);
		txn_t t;
		t.opcode = op;
		t.ori = rps_pkg::ORIF_W'($urandom);
		t.x = rps_pkg::CXY_W'($urandom);
		t.y = rps_pkg::CXY_W'($urandom);
		t.z = rps_pkg::CZ_W'($urandom);
		t.value = rps_pkg::SCORE_W'($urandom);
		t.path = rps_pkg::PATHF_W'($urandom);
		t.dx = rps_pkg::OFS_W'($urandom);
		t.dy = rps_pkg::OFS_W'($urandom);
		return t;
	endfunction

	function automatic logic [rps_pkg::SCORE_W-1:0] pick_score();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return rps_pkg::SCORE_W'($urandom);
		endcase
	endfunction

	// Mostly inside the grid in use, now and then anywhere in the field
	function automatic int pick_coord(input int lim, input int maxv);
		if ($urandom_range(9) == 0)
			return $urandom_range(maxv);
		return $urandom_range((lim < maxv) ? lim : maxv);
	endfunction

	// Send one transaction in bursts with random gaps; called and returns at a falling edge
	task automatic send_txn(input txn_t t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(8);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		in_ch.opcode      <= t.opcode;
		in_ch.ori_index   <= t.ori;
		in_ch.cell_x      <= t.x;
		in_ch.cell_y      <= t.y;
		in_ch.cell_z      <= t.z;
		in_ch.score_value <= t.value;
		in_ch.path_index  <= t.path;
		in_ch.offset_x    <= t.dx;
		in_ch.offset_y    <= t.dy;
		in_ch.valid       <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		apply_txn(t);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_cell_op(input rps_pkg::op_t op, input int o, input int x, input int y,
			input int z, input int v, input int path);
		txn_t t;
		t = rand_txn(op);
		t.ori = rps_pkg::ORIF_W'(o);
		t.x = rps_pkg::CXY_W'(x);
		t.y = rps_pkg::CXY_W'(y);
		t.z = rps_pkg::CZ_W'(z);
		t.value = rps_pkg::SCORE_W'(v);
		t.path = rps_pkg::PATHF_W'(path);
		send_txn(t);
	endtask

	// Score at an offset; shift the pattern fully off the grid if a read would hit an empty cell
	task automatic score_at(input int dx, input int dy);
		txn_t t;
		t = rand_txn(rps_pkg::OP_SCORE);
		if (!reads_defined(dx, dy))
			dx = OFS_MAX;
		t.dx = rps_pkg::OFS_W'(dx);
		t.dy = rps_pkg::OFS_W'(dy);
		send_txn(t);
	endtask

	// Write every in-grid cell the pattern touches at this offset (some again with new values)
	task automatic cover_cells(input int dx, input int dy);
		rps_pkg::pt_t snap [$];
		int           addr;
		txn_t         t;
		snap = stored_pts;
		foreach (snap[i]) begin
			if (grid_cell(snap[i], dx, dy, addr) &&
					(!cell_written[addr] || $urandom_range(3) == 0)) begin
				t = rand_txn(rps_pkg::OP_WRITE);
				t.ori = snap[i].ori;
				t.x = rps_pkg::CXY_W'(int'(snap[i].x) + dx);
				t.y = rps_pkg::CXY_W'(int'(snap[i].y) + dy);
				t.z = snap[i].z;
				t.value = pick_score();
				send_txn(t);
			end
		end
	endtask

	task automatic send_noise();
		txn_t t;
		t = rand_txn(rps_pkg::op_t'($urandom_range(3)));
		if (t.opcode == rps_pkg::OP_SCORE)
			score_at(t.dx, t.dy);
		else
			send_txn(t);
	endtask

	task automatic append_near_grid(input int paths_used);
		txn_t t;
		t = rand_txn(rps_pkg::OP_APPEND);
		t.path = rps_pkg::PATHF_W'($urandom_range(paths_used - 1));
		t.ori = rps_pkg::ORIF_W'(pick_coord(in_use(ori_n, rps_pkg::MAX_ORI), 31));
		t.x = rps_pkg::CXY_W'(pick_coord(in_use(grid_x_n, rps_pkg::MAX_X), 63));
		t.y = rps_pkg::CXY_W'(pick_coord(in_use(grid_y_n, rps_pkg::MAX_Y), 63));
		t.z = rps_pkg::CZ_W'(pick_coord(in_use(grid_z_n, rps_pkg::MAX_Z), 15));
		send_txn(t);
	endtask

	// Build a pattern, fill the cells it reads, then score it at a few offsets
	task automatic run_scene(input int max_pts, input int n_ofs);
		int paths_used;
		int dx;
		int dy;
		if ($urandom_range(4) != 0)
			send_txn(rand_txn(rps_pkg::OP_CLEAR));
		paths_used = $urandom_range(1, rps_pkg::MAX_PATHS);
		repeat ($urandom_range(1, max_pts)) begin
			append_near_grid(paths_used);
			if ($urandom_range(9) == 0)
				send_noise();
		end
		repeat (n_ofs) begin
			if ($urandom_range(7) == 0) begin
				dx = int'($urandom_range(127)) - 64;
				dy = int'($urandom_range(127)) - 64;
			end else begin
				dx = int'($urandom_range(6)) - 3;
				dy = int'($urandom_range(6)) - 3;
			end
			cover_cells(dx, dy);
			if ($urandom_range(7) == 0)
				send_noise();
			score_at(dx, dy);
		end
	endtask

	// Drop valid, wait for every pending score, then let the block drain
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (expected_scores.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_grid(input logic [rps_pkg::CFG_DATA_W-1:0] gx,
			input logic [rps_pkg::CFG_DATA_W-1:0] gy,
			input logic [rps_pkg::CFG_DATA_W-1:0] gz,
			input logic [rps_pkg::CFG_DATA_W-1:0] go);
		logic [rps_pkg::CFG_DATA_W-1:0] vals [4];
		logic [rps_pkg::CFG_IDX_W-1:0]  idx [4];
		int i;
		settle();
		vals = '{gx, gy, gz, go};
		idx = '{rps_pkg::CFG_GRID_X, rps_pkg::CFG_GRID_Y, rps_pkg::CFG_GRID_Z, rps_pkg::CFG_ORI};
		for (i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		grid_x_n = gx[rps_pkg::CFGX_W-1:0];
		grid_y_n = gy[rps_pkg::CFGY_W-1:0];
		grid_z_n = gz[rps_pkg::CFGZ_W-1:0];
		ori_n = go[rps_pkg::CFGO_W-1:0];
	endtask

	// Extremes of the fields, ignored writes, zero and outside-grid points, empty pattern
	task automatic test_directed();
		score_at(0, 0);
		send_cell_op(rps_pkg::OP_WRITE, 31, 15, 15, 7, 16'hFFFF, 0);
		send_cell_op(rps_pkg::OP_WRITE, 0, 0, 0, 0, 1, 0);
		send_cell_op(rps_pkg::OP_WRITE, 0, 1, 0, 0, 0, 0);
		send_cell_op(rps_pkg::OP_WRITE, 0, 16, 0, 0, 7, 0);
		send_cell_op(rps_pkg::OP_WRITE, 0, 0, 63, 0, 7, 0);
		send_cell_op(rps_pkg::OP_WRITE, 0, 0, 0, 15, 7, 0);
		send_cell_op(rps_pkg::OP_APPEND, 0, 0, 0, 0, 0, 0);
		send_cell_op(rps_pkg::OP_APPEND, 31, 15, 15, 7, 0, 7);
		send_cell_op(rps_pkg::OP_APPEND, 0, 1, 0, 0, 0, 3);
		send_cell_op(rps_pkg::OP_APPEND, 0, 63, 63, 15, 0, 5);
		score_at(0, 0);
		score_at(-64, -64);
		score_at(63, 63);
		send_cell_op(rps_pkg::OP_WRITE, 31, 14, 15, 7, 16'h8000, 0);
		score_at(-1, 0);
		send_cell_op(rps_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
		score_at(0, 0);
	endtask

	// Overfill the pattern; appends past the last slot are dropped
	task automatic test_full_pattern();
		send_txn(rand_txn(rps_pkg::OP_CLEAR));
		repeat (rps_pkg::MAX_POINTS + 6)
			append_near_grid(rps_pkg::MAX_PATHS);
		cover_cells(0, 0);
		score_at(0, 0);
		cover_cells(1, -1);
		score_at(1, -1);
		append_near_grid(rps_pkg::MAX_PATHS);
		score_at(0, 0);
	endtask

	task automatic grid_phase(input int gx, input int gy, input int gz, input int go);
		set_grid(rps_pkg::CFG_DATA_W'(gx), rps_pkg::CFG_DATA_W'(gy), rps_pkg::CFG_DATA_W'(gz),
			rps_pkg::CFG_DATA_W'(go));
		repeat (3) run_scene(8, 2);
	endtask

	// Smallest, zero, oversized and mixed grid settings
	task automatic test_grid_settings();
		grid_phase(1, 1, 1, 1);
		grid_phase(0, 0, 0, 0);
		grid_phase(31, 31, 15, 63);
		grid_phase(16, 1, 1, 32);
		grid_phase(2, 16, 8, 5);
		grid_phase(16, 16, 8, 32);
	endtask

	// Hold the result side off so the output register fills and input stalls
	task automatic test_backpressure();
		send_txn(rand_txn(rps_pkg::OP_CLEAR));
		repeat (6) append_near_grid(4);
		cover_cells(0, 0);
		cover_cells(2, -1);
		hold_request = 400;
		repeat (4) begin
			score_at(0, 0);
			score_at(2, -1);
		end
	endtask

	task automatic test_random_traffic();
		int scenes;
		scenes = 0;
		while (items_sent < ITEM_TARGET) begin
			if (scenes % 6 == 0) begin
				if ($urandom_range(3) == 0)
					set_grid(rps_pkg::CFG_DATA_W'($urandom), rps_pkg::CFG_DATA_W'($urandom),
						rps_pkg::CFG_DATA_W'($urandom), rps_pkg::CFG_DATA_W'($urandom));
				else
					set_grid(rps_pkg::CFG_DATA_W'($urandom_range(1, 16)),
						rps_pkg::CFG_DATA_W'($urandom_range(1, 16)),
						rps_pkg::CFG_DATA_W'($urandom_range(1, 8)),
						rps_pkg::CFG_DATA_W'($urandom_range(1, 32)));
			end
			run_scene(($urandom_range(11) == 0) ? 40 : 10, $urandom_range(1, 3));
			scenes++;
		end
	endtask

	// Result side: stall in windows of random density, honor a long hold when asked
	initial begin : result_ready
		int stall_pct;
		int window_len;
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(80);
			window_len = $urandom_range(20, 200);
			repeat (window_len) begin
				@(negedge clk);
				if (hold_request > 0) begin
					hold_left = hold_request;
					hold_request = 0;
				end
				if (hold_left > 0) begin
					out_ch.ready <= 1'b0;
					hold_left--;
				end else begin
					out_ch.ready <= ($urandom_range(99) >= stall_pct);
				end
			end
		end
	end

	// Compare each accepted result with the oldest predicted score
	always @(posedge clk) begin : score_check
		score_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_scores.size() == 0) begin
				report_mismatch("score result with no score transaction pending");
			end else begin
				want = expected_scores.pop_front();
				if (out_ch.total_score !== want.total || out_ch.path_mask !== want.mask ||
						out_ch.is_match !== want.match)
					report_mismatch($sformatf(
						"score got total %0d mask %02h match %0b, predicted %0d %02h %0b",
						out_ch.total_score, out_ch.path_mask, out_ch.is_match,
						want.total, want.mask, want.match));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.ori_index = '0;
		in_ch.cell_x = '0;
		in_ch.cell_y = '0;
		in_ch.cell_z = '0;
		in_ch.score_value = '0;
		in_ch.path_index = '0;
		in_ch.offset_x = '0;
		in_ch.offset_y = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_full_pattern();
		test_grid_settings();
		test_backpressure();
		test_random_traffic();

		settle();
		if (expected_scores.size() != 0)
			report_mismatch($sformatf("%0d predicted scores never arrived",
				expected_scores.size()));
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: reachability_pattern_scorer.f
rtl/rps_pkg.sv
rtl/rps_chan_if.sv
rtl/rps_ram.sv
rtl/rps_acc.sv
rtl/rps_seq.sv
rtl/reachability_pattern_scorer.sv
sim/testbench.sv
